// ===== rtl/mhic_pkg.sv =====
// Shared types, constants and arithmetic helpers for the magnetometer hard-iron calibrator.
package mhic_pkg;

	localparam int NUM_LANES = 3;

	typedef logic [2:0] cfg_idx_t;

	localparam cfg_idx_t CFG_GAIN_X        = 3'd0;
	localparam cfg_idx_t CFG_GAIN_Y        = 3'd1;
	localparam cfg_idx_t CFG_GAIN_Z        = 3'd2;
	localparam cfg_idx_t CFG_OFFSET_ENABLE = 3'd3;
	localparam cfg_idx_t CFG_WINDOW_US     = 3'd4;
	localparam cfg_idx_t CFG_TILT_MODE     = 3'd5;

	localparam logic [1:0] TILT_LEFT  = 2'd1;
	localparam logic [1:0] TILT_RIGHT = 2'd2;

	localparam logic [15:0] GAIN_RESET   = 16'd4096;
	localparam logic [31:0] WINDOW_RESET = 32'd30000000;

	// x/10 as (x * ceil(2^22/10)) >> 22, exact for x < 2^19
	localparam int          RECIP_SHIFT = 22;
	localparam logic [18:0] RECIP_10    = 19'd419431;

	typedef struct packed {
		logic start;
		logic offset_en;
		logic track;
		logic close;
	} lane_ctrl_t;

	function automatic logic signed [15:0] sat16(input logic signed [23:0] v);
		logic signed [15:0] r;
		if (v > 24'sd32767)
			r = 16'sh7FFF;
		else if (v < -24'sd32768)
			r = 16'sh8000;
		else
			r = v[15:0];
		return r;
	endfunction

	// (s * 7) / 10, truncated toward zero, saturated to 16 bits
	function automatic logic signed [15:0] mul_7_10(input logic signed [16:0] s);
		logic signed [19:0] ext;
		logic signed [19:0] m;
		logic               neg;
		logic [18:0]        mag;
		logic [37:0]        p;
		logic [15:0]        q;
		logic signed [16:0] r;
		ext = {{3{s[16]}}, s};
		m   = (ext <<< 3) - ext;
		neg = m[19];
		mag = neg ? 19'(-m) : m[18:0];
		p   = mag * RECIP_10;
		q   = p[RECIP_SHIFT+15:RECIP_SHIFT];
		r   = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
		return sat16({{7{r[16]}}, r});
	endfunction

endpackage

// ===== rtl/mhic_lane.sv =====
// One axis lane: gain scaling; with CAL set, also offset subtraction and min/max/offset tracking.
module mhic_lane #(
	parameter bit CAL = 1'b1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     load,
	input  logic                     adv,
	input  logic signed [15:0]       raw,
	input  logic [15:0]              gain,
	input  mhic_pkg::lane_ctrl_t     ctrl,
	output logic signed [15:0]       val_s2
);

	logic signed [32:0] prod;
	logic signed [32:0] prod_adj;
	logic signed [20:0] quo;
	logic signed [15:0] scaled_s1;

	// truncate toward zero: bias negatives before the arithmetic shift
	assign prod     = $signed({{17{raw[15]}}, raw}) * $signed({17'b0, gain});
	assign prod_adj = prod + (prod[32] ? 33'sd4095 : 33'sd0);
	assign quo      = prod_adj[32:12];

	always_ff @(posedge clk) begin
		if (load)
			scaled_s1 <= mhic_pkg::sat16({{3{quo[20]}}, quo});
	end

	if (CAL) begin : g_cal
		logic signed [15:0] min_q, max_q, off_q;
		logic signed [15:0] off_eff, min_base, max_base, corr;
		logic signed [16:0] diff, mid_sum;

		assign off_eff  = ctrl.start ? 16'sd0 : off_q;
		assign min_base = ctrl.start ? scaled_s1 : min_q;
		assign max_base = ctrl.start ? scaled_s1 : max_q;
		assign diff     = {scaled_s1[15], scaled_s1} - {off_eff[15], off_eff};
		assign corr     = ctrl.offset_en ? mhic_pkg::sat16({{7{diff[16]}}, diff}) : scaled_s1;
		assign mid_sum  = {min_base[15], min_base} + {max_base[15], max_base};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				min_q <= '0;
				max_q <= '0;
				off_q <= '0;
			end else if (adv) begin
				if (ctrl.track) begin
					min_q <= (corr < min_base) ? corr : min_base;
					max_q <= (corr > max_base) ? corr : max_base;
				end else if (ctrl.start) begin
					min_q <= scaled_s1;
					max_q <= scaled_s1;
				end
				if (ctrl.close) begin
					off_q <= 16'(mid_sum >>> 1);
				end else if (ctrl.start) begin
					off_q <= '0;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv)
				val_s2 <= corr;
		end
	end else begin : g_plain
		always_ff @(posedge clk) begin
			if (adv)
				val_s2 <= scaled_s1;
		end
	end

endmodule

// ===== rtl/mhic_tilt.sv =====
// Merging stage: 45-degree tilt rotation of the X and Y lane results in the tilt modes, else pass-through.
module mhic_tilt (
	input  logic signed [15:0] x,
	input  logic signed [15:0] y,
	input  logic [1:0]         mode,
	output logic signed [15:0] nx,
	output logic signed [15:0] ny
);

	logic signed [16:0] sum, dxy, dyx;

	assign sum = {x[15], x} + {y[15], y};
	assign dxy = {x[15], x} - {y[15], y};
	assign dyx = {y[15], y} - {x[15], x};

	always_comb begin
		case (mode)
			mhic_pkg::TILT_LEFT: begin
				nx = mhic_pkg::mul_7_10(sum);
				ny = mhic_pkg::mul_7_10(dyx);
			end
			mhic_pkg::TILT_RIGHT: begin
				nx = mhic_pkg::mul_7_10(dxy);
				ny = mhic_pkg::mul_7_10(sum);
			end
			default: begin
				nx = x;
				ny = y;
			end
		endcase
	end

endmodule

// ===== rtl/mag_hard_iron_calibrator_core.sv =====
// Top level of the magnetometer hard-iron calibrator.
// Each input item is one three-axis sample with a microsecond timestamp and yields one
// corrected sample. An item passes three register stages: gain scaling in the axis lanes,
// offset correction plus min/max/window update, then tilt rotation into the output
// register. A new item is taken only after the previous one has left the first stage, a
// limit set by the window and min/max state, which each item updates before the next may
// use it; the output register lets an item enter while the previous result waits. Raising
// start_calibration (tuser) on a sample restarts a calibration window of window_us
// microseconds; the result's tuser reports that the window is still open.
module mag_hard_iron_calibrator_core #(
	parameter int AXES = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [79:0] s_axis_tdata,   // mag_x, mag_y, mag_z, time_us
	input  logic [0:0]  s_axis_tuser,   // start_calibration
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,   // field_x, field_y, field_z
	output logic [0:0]  m_axis_tuser,   // calibrating
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [31:0] cfg_data
);

	localparam int NL = mhic_pkg::NUM_LANES;

	logic [15:0] gain_q [NL];
	logic        offset_en_q;
	logic [31:0] window_us_q;
	logic [1:0]  tilt_mode_q;

	logic        win_open_q;
	logic [31:0] win_start_q;

	logic        v1_q, v2_q;
	logic [31:0] now_s1;
	logic        start_s1;
	logic        tilt_s2;
	logic        calib_s2;

	logic               acc, adv, mv2;
	logic               open_eff, track;
	logic [31:0]        base, elapsed;
	mhic_pkg::lane_ctrl_t ctrl;
	logic signed [15:0] lane_val [NL];
	logic signed [15:0] rot_x, rot_y;

	// config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NL; i++)
				gain_q[i] <= mhic_pkg::GAIN_RESET;
			offset_en_q <= 1'b0;
			window_us_q <= mhic_pkg::WINDOW_RESET;
			tilt_mode_q <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				mhic_pkg::CFG_GAIN_X:        gain_q[0]   <= cfg_data[15:0];
				mhic_pkg::CFG_GAIN_Y:        gain_q[1]   <= cfg_data[15:0];
				mhic_pkg::CFG_GAIN_Z:        gain_q[2]   <= cfg_data[15:0];
				mhic_pkg::CFG_OFFSET_ENABLE: offset_en_q <= cfg_data[0];
				mhic_pkg::CFG_WINDOW_US:     window_us_q <= cfg_data;
				mhic_pkg::CFG_TILT_MODE:     tilt_mode_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// handshake and stage valids
	assign mv2           = v2_q && (!m_axis_tvalid || m_axis_tready);
	assign s_axis_tready = !v1_q && (!v2_q || mv2);
	assign acc           = s_axis_tvalid && s_axis_tready;
	assign adv           = v1_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q          <= 1'b0;
			v2_q          <= 1'b0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (acc)
				v1_q <= 1'b1;
			else if (adv)
				v1_q <= 1'b0;
			if (adv)
				v2_q <= 1'b1;
			else if (mv2)
				v2_q <= 1'b0;
			if (mv2)
				m_axis_tvalid <= 1'b1;
			else if (m_axis_tready)
				m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			now_s1   <= s_axis_tdata[79:48];
			start_s1 <= s_axis_tuser[0];
		end
	end

	// window control
	assign open_eff = start_s1 || win_open_q;
	assign base     = start_s1 ? now_s1 : win_start_q;
	assign elapsed  = now_s1 - base;
	assign track    = open_eff && (elapsed < window_us_q);

	assign ctrl.start     = start_s1;
	assign ctrl.offset_en = offset_en_q;
	assign ctrl.track     = track;
	assign ctrl.close     = open_eff && !track;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_open_q  <= 1'b0;
			win_start_q <= '0;
		end else if (adv) begin
			win_open_q <= track;
			if (start_s1)
				win_start_q <= now_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			calib_s2 <= track;
			tilt_s2  <= !open_eff && (AXES >= 2) &&
				(tilt_mode_q == mhic_pkg::TILT_LEFT || tilt_mode_q == mhic_pkg::TILT_RIGHT);
		end
	end

	// lanes
	for (genvar i = 0; i < NL; i++) begin : g_lane
		mhic_lane #(
			.CAL (i < AXES)
		) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.load   (acc),
			.adv    (adv),
			.raw    ($signed(s_axis_tdata[16*i +: 16])),
			.gain   (gain_q[i]),
			.ctrl   (ctrl),
			.val_s2 (lane_val[i])
		);
	end

	mhic_tilt u_tilt (
		.x    (lane_val[0]),
		.y    (lane_val[1]),
		.mode (tilt_mode_q),
		.nx   (rot_x),
		.ny   (rot_y)
	);

	always_ff @(posedge clk) begin
		if (mv2) begin
			m_axis_tdata[15:0]  <= tilt_s2 ? rot_x : lane_val[0];
			m_axis_tdata[31:16] <= tilt_s2 ? rot_y : lane_val[1];
			m_axis_tdata[47:32] <= lane_val[2];
			m_axis_tuser[0]     <= calib_s2;
		end
	end

	// checks
	a_one_stage: assert property (@(posedge clk) disable iff (!arst_n)
		!(v1_q && v2_q))
		else $error("two items in flight");

	a_handoff: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> v2_q && !v1_q)
		else $error("stage handoff lost");

	a_win_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(win_open_q) && $stable(win_start_q))
		else $error("window state moved without an item");

	a_out_flag: assert property (@(posedge clk) disable iff (!arst_n)
		mv2 |=> m_axis_tvalid && m_axis_tuser[0] == $past(calib_s2))
		else $error("result flag mismatch");

endmodule
